// ===== sv/spqr_pkg.sv =====
package spqr_pkg;

	localparam int DEPTH  = 16;
	localparam int LEVELS = 8;

	localparam int KIND_W   = 2;
	localparam int HANDLE_W = 16;
	localparam int KEY_W    = 32;
	localparam int LVL_W    = 3;
	localparam int STAT_W   = 2;
	localparam int CNT_W    = $clog2(DEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT   = 2'd0,
		KIND_DISPATCH = 2'd1,
		KIND_FIND     = 2'd2,
		KIND_REMOVE   = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_NOKEY = 2'd3
	} status_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [KEY_W-1:0]    key;
		logic [LVL_W-1:0]    level;
	} entry_t;

	typedef struct packed {
		kind_t  kind;
		entry_t ent;
	} op_t;

	function automatic logic [LVL_W-1:0] sat_level(input logic [LVL_W-1:0] lvl);
		logic [LVL_W-1:0] top_lvl;
		top_lvl = LVL_W'(LEVELS - 1);
		return (lvl > top_lvl) ? top_lvl : lvl;
	endfunction

endpackage

// ===== sv/spqr_cell.sv =====
module spqr_cell (
	input  logic                          clk,
	input  logic                          upd,
	input  spqr_pkg::op_t                 op,
	input  logic                          occupied,
	input  logic                          left_ge,
	input  spqr_pkg::entry_t              left_ent,
	input  spqr_pkg::entry_t              right_ent,
	input  logic                          seen_in,
	input  logic [spqr_pkg::HANDLE_W-1:0] hit_in,
	output spqr_pkg::entry_t              ent,
	output logic                          ge,
	output logic                          seen_out,
	output logic [spqr_pkg::HANDLE_W-1:0] hit_out
);
	import spqr_pkg::*;

	entry_t ent_q;
	entry_t ent_d;
	logic   match;

	assign ent      = ent_q;
	assign ge       = occupied && (ent_q.level >= op.ent.level);
	assign match    = occupied && (ent_q.key == op.ent.key);
	assign seen_out = seen_in || match;
	assign hit_out  = seen_in ? hit_in : ent_q.handle;

	always_comb begin
		ent_d = ent_q;
		case (op.kind)
			KIND_INSERT: begin
				if (ge) begin
					ent_d = ent_q;
				end else if (left_ge) begin
					ent_d = op.ent;
				end else begin
					ent_d = left_ent;
				end
			end
			KIND_DISPATCH: ent_d = right_ent;
			KIND_REMOVE: begin
				if (seen_out) begin
					ent_d = right_ent;
				end
			end
			default: ent_d = ent_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			ent_q <= ent_d;
		end
	end

endmodule

// ===== sv/stable_priority_queue_with_removal_top.sv =====
// The result word is registered and appears in the cycle after its word is accepted.
// Throughput: one word per cycle; a word is held off only while a result waits
// under out_stall, since the single result register must drain first.
// Every operation is settled by the row of cells comparing at once.
// Reset clears the entry count and the result valid; cell contents and result fields are not reset.
module stable_priority_queue_with_removal_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [spqr_pkg::KIND_W-1:0]   kind,
	input  logic [spqr_pkg::HANDLE_W-1:0] item_handle,
	input  logic [spqr_pkg::KEY_W-1:0]    item_key,
	input  logic [spqr_pkg::LVL_W-1:0]    service_level,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [spqr_pkg::STAT_W-1:0]   status,
	output logic [spqr_pkg::HANDLE_W-1:0] out_handle,
	output logic [spqr_pkg::CNT_W-1:0]    occupancy
);
	import spqr_pkg::*;

	op_t                 op;
	logic                accept;
	logic                full;
	logic                empty;
	logic                found;
	logic                upd;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	status_t             stat_d;
	logic [HANDLE_W-1:0] hnd_d;
	logic                out_valid_q;
	status_t             status_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [CNT_W-1:0]    occupancy_q;

	entry_t              ent   [DEPTH];
	logic                ge    [DEPTH];
	logic                seen  [DEPTH+1];
	logic [HANDLE_W-1:0] hit   [DEPTH+1];

	assign op.kind          = kind_t'(kind);
	assign op.ent.handle    = item_handle;
	assign op.ent.key       = item_key;
	assign op.ent.level     = sat_level(service_level);

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign found    = seen[DEPTH];

	assign seen[0] = 1'b0;
	assign hit[0]  = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_ent;
		entry_t right_ent;
		logic   left_ge;
		if (i == 0) begin : g_head
			assign left_ent = op.ent;
			assign left_ge  = 1'b1;
		end else begin : g_body
			assign left_ent = ent[i-1];
			assign left_ge  = ge[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_ent = ent[i];
		end else begin : g_mid
			assign right_ent = ent[i+1];
		end
		spqr_cell u_cell (
			.clk       (clk),
			.upd       (upd),
			.op        (op),
			.occupied  (CNT_W'(i) < count_q),
			.left_ge   (left_ge),
			.left_ent  (left_ent),
			.right_ent (right_ent),
			.seen_in   (seen[i]),
			.hit_in    (hit[i]),
			.ent       (ent[i]),
			.ge        (ge[i]),
			.seen_out  (seen[i+1]),
			.hit_out   (hit[i+1])
		);
	end

	always_comb begin
		upd     = 1'b0;
		count_d = count_q;
		stat_d  = ST_OK;
		hnd_d   = '0;
		case (op.kind)
			KIND_INSERT: begin
				if (full) begin
					stat_d = ST_FULL;
				end else begin
					upd     = accept;
					count_d = count_q + 1'b1;
				end
			end
			KIND_DISPATCH: begin
				if (empty) begin
					stat_d = ST_EMPTY;
				end else begin
					upd     = accept;
					count_d = count_q - 1'b1;
					hnd_d   = ent[0].handle;
				end
			end
			KIND_FIND: begin
				if (!found) begin
					stat_d = ST_NOKEY;
				end else begin
					hnd_d = hit[DEPTH];
				end
			end
			KIND_REMOVE: begin
				if (!found) begin
					stat_d = ST_NOKEY;
				end else begin
					upd     = accept;
					count_d = count_q - 1'b1;
				end
			end
			default: stat_d = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= stat_d;
			out_handle_q <= hnd_d;
			occupancy_q  <= count_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_handle = out_handle_q;
	assign occupancy  = occupancy_q;

endmodule

// ===== sv/spqr_chk.sv =====
module spqr_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [spqr_pkg::STAT_W-1:0]   status,
	input logic [spqr_pkg::HANDLE_W-1:0] out_handle,
	input logic [spqr_pkg::CNT_W-1:0]    occupancy
);
	import spqr_pkg::*;

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occupancy <= CNT_W'(DEPTH)))
		else $error("occupancy beyond depth");

	a_full_at_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (occupancy == CNT_W'(DEPTH)))
		else $error("full status below depth");

	a_empty_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (occupancy == '0))
		else $error("empty status with entries held");

	a_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (out_handle == '0))
		else $error("handle on failed word");

	a_word_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted word gave no result");

endmodule

bind stable_priority_queue_with_removal_top spqr_chk u_spqr_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.out_handle (out_handle),
	.occupancy  (occupancy)
);
